// File: rtl/hfcc_pkg.sv
`default_nettype none
package hfcc_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  BYTE_ONES   = 8'hFF;
    localparam int unsigned TEMP_SPAN   = 17500;
    localparam int unsigned HUM_SPAN    = 10000;
    localparam logic [15:0] TEMP_OFFSET = 16'd4500;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned TEMP_W      = 15;
    localparam int unsigned HUM_W       = 14;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BUS      = 3'd1,
        ST_ALL_ONES = 3'd2,
        ST_TEMP_CRC = 3'd3,
        ST_HUM_CRC  = 3'd4
    } status_t;

    // per-beat checks that do not depend on a lane
    typedef struct packed {
        logic bus_err;
        logic all_ones;
    } frame_flags_t;

    // load strobes for the two lane stages
    typedef struct packed {
        logic s1;
        logic s2;
    } lane_ld_t;

    // MSB-first CRC-8 update over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/hfcc_in_if.sv
`default_nettype none
interface hfcc_in_if;
    logic       valid;
    logic       ready;
    logic       transfer_ok;
    logic [7:0] temp_high;
    logic [7:0] temp_low;
    logic [7:0] temp_check;
    logic [7:0] hum_high;
    logic [7:0] hum_low;
    logic [7:0] hum_check;

    modport source (output valid, transfer_ok, temp_high, temp_low, temp_check,
                    hum_high, hum_low, hum_check, input ready);
    modport sink   (input valid, transfer_ok, temp_high, temp_low, temp_check,
                    hum_high, hum_low, hum_check, output ready);
endinterface
`default_nettype wire

// File: rtl/hfcc_out_if.sv
`default_nettype none
interface hfcc_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic               temp_valid;
    logic signed [14:0] temperature_centi;
    logic               hum_valid;
    logic [13:0]        humidity_centi;

    modport source (output valid, status, temp_valid, temperature_centi, hum_valid,
                    humidity_centi, input ready);
    modport sink   (input valid, status, temp_valid, temperature_centi, hum_valid,
                    humidity_centi, output ready);
endinterface
`default_nettype wire

// File: rtl/hfcc_lane.sv
`default_nettype none
// One word lane: CRC over two bytes and floor(SPAN*word/65535), two stages.
module hfcc_lane #(
    parameter int unsigned SPAN = 17500
) (
    input  wire                                clk,
    input  wire  hfcc_pkg::lane_ld_t           ld,
    input  wire  [7:0]                         word_high,
    input  wire  [7:0]                         word_low,
    input  wire  [7:0]                         word_check,
    output logic                               crc_ok,
    output logic [$clog2(SPAN + 1) - 1:0]      quot
);
    localparam int unsigned PROD_W = $clog2(SPAN * 65535 + 1);
    localparam int unsigned Q_W    = $clog2(SPAN + 1);
    localparam logic [PROD_W-1:0] SPAN_W = PROD_W'(SPAN);

    logic [7:0]        crc1_reg;
    logic [7:0]        low_reg;
    logic [7:0]        check_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              ok_reg;
    logic [Q_W-1:0]    quot_reg;

    logic [PROD_W-1:0] prod_next;
    logic [7:0]        crc1_next;
    logic [7:0]        crc2;
    logic [PROD_W:0]   sum_w;
    logic [Q_W-1:0]    quot_next;

    assign prod_next = SPAN_W * PROD_W'({word_high, word_low});
    assign crc1_next = hfcc_pkg::crc8_byte(hfcc_pkg::CRC_INIT, word_high);
    assign crc2      = hfcc_pkg::crc8_byte(crc1_reg, low_reg);

    // x/65535 == (x + (x >> 16) + 1) >> 16 for the product range here
    assign sum_w     = {1'b0, prod_reg} + (PROD_W + 1)'(prod_reg >> 16) + (PROD_W + 1)'(1);
    assign quot_next = Q_W'(sum_w >> 16);

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            crc1_reg  <= crc1_next;
            low_reg   <= word_low;
            check_reg <= word_check;
            prod_reg  <= prod_next;
        end
        if (ld.s2)
        begin
            ok_reg   <= (crc2 == check_reg);
            quot_reg <= quot_next;
        end
    end

    assign crc_ok = ok_reg;
    assign quot   = quot_reg;
endmodule
`default_nettype wire

// File: rtl/hfcc_merge.sv
`default_nettype none
// Combines lane checks into status and readings; holds the output register.
module hfcc_merge (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  hfcc_pkg::frame_flags_t flags,
    input  wire                          temp_ok,
    input  wire  [hfcc_pkg::TEMP_W-1:0]  temp_quot,
    input  wire                          hum_ok,
    input  wire  [hfcc_pkg::HUM_W-1:0]   hum_quot,
    hfcc_out_if.source                   result
);
    logic                         valid_reg;
    logic [2:0]                   status_reg;
    logic                         tvalid_reg;
    logic [hfcc_pkg::TEMP_W-1:0]  temp_reg;
    logic                         hvalid_reg;
    logic [hfcc_pkg::HUM_W-1:0]   hum_reg;

    hfcc_pkg::status_t            status_next;
    logic                         tvalid_next;
    logic                         hvalid_next;
    logic [15:0]                  temp_diff;

    assign in_ready  = !valid_reg || result.ready;
    assign temp_diff = {1'b0, temp_quot} - hfcc_pkg::TEMP_OFFSET;

    always_comb
    begin
        tvalid_next = 1'b0;
        hvalid_next = 1'b0;
        priority if (flags.bus_err)
        begin
            status_next = hfcc_pkg::ST_BUS;
        end
        else if (flags.all_ones)
        begin
            status_next = hfcc_pkg::ST_ALL_ONES;
        end
        else if (!temp_ok)
        begin
            status_next = hfcc_pkg::ST_TEMP_CRC;
        end
        else if (!hum_ok)
        begin
            status_next = hfcc_pkg::ST_HUM_CRC;
            tvalid_next = 1'b1;
        end
        else
        begin
            status_next = hfcc_pkg::ST_OK;
            tvalid_next = 1'b1;
            hvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            status_reg <= status_next;
            tvalid_reg <= tvalid_next;
            hvalid_reg <= hvalid_next;
            temp_reg   <= tvalid_next ? temp_diff[hfcc_pkg::TEMP_W-1:0] : '0;
            hum_reg    <= hvalid_next ? hum_quot : '0;
        end
    end

    assign result.valid             = valid_reg;
    assign result.status            = status_reg;
    assign result.temp_valid        = tvalid_reg;
    assign result.temperature_centi = signed'(temp_reg);
    assign result.hum_valid         = hvalid_reg;
    assign result.humidity_centi    = hum_reg;

    a_ok_both_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == hfcc_pkg::ST_OK) |-> (tvalid_reg && hvalid_reg))
        else $error("ok status without both readings valid");

    a_hum_needs_temp: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && hvalid_reg) |-> tvalid_reg)
        else $error("humidity valid while temperature not valid");

    a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != hfcc_pkg::ST_OK && status_reg != hfcc_pkg::ST_HUM_CRC)
        |-> (!tvalid_reg && !hvalid_reg && temp_reg == '0 && hum_reg == '0))
        else $error("failed frame carries readings");

    a_hum_crc_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == hfcc_pkg::ST_HUM_CRC) |-> (tvalid_reg && hum_reg == '0))
        else $error("humidity CRC fail with wrong fields");
endmodule
`default_nettype wire

// File: rtl/humidity_frame_check_convert.sv
`default_nettype none
// Checks a six-byte temperature/humidity reply (bus flag, all-ones reply, CRC-8 poly 0x31
// init 0xFF per word) and scales the words to centidegrees and centipercent with floor
// rounding. The two words run in separate lanes of two stages each (first CRC byte and
// the span multiply, then second CRC byte and the divide by 65535), followed by the
// merge stage with the output register. A new beat is taken every cycle while results
// are drained.
module humidity_frame_check_convert (
    input wire          clk,
    input wire          rst_n,
    hfcc_in_if.sink     sample,
    hfcc_out_if.source  result
);
    logic                   v1_reg;
    logic                   v2_reg;
    hfcc_pkg::frame_flags_t flags1_reg;
    hfcc_pkg::frame_flags_t flags2_reg;

    hfcc_pkg::frame_flags_t flags_next;
    hfcc_pkg::lane_ld_t     ld;
    logic                   take1;
    logic                   take2;
    logic                   merge_ready;
    logic                   temp_ok;
    logic                   hum_ok;
    logic [hfcc_pkg::TEMP_W-1:0] temp_quot;
    logic [hfcc_pkg::HUM_W-1:0]  hum_quot;

    assign take2        = !v2_reg || merge_ready;
    assign take1        = !v1_reg || take2;
    assign sample.ready = take1;
    assign ld.s1        = sample.valid && take1;
    assign ld.s2        = v1_reg && take2;

    assign flags_next.bus_err  = !sample.transfer_ok;
    assign flags_next.all_ones = (sample.temp_high == hfcc_pkg::BYTE_ONES)
                              && (sample.temp_low == hfcc_pkg::BYTE_ONES)
                              && (sample.temp_check == hfcc_pkg::BYTE_ONES)
                              && (sample.hum_high == hfcc_pkg::BYTE_ONES)
                              && (sample.hum_low == hfcc_pkg::BYTE_ONES)
                              && (sample.hum_check == hfcc_pkg::BYTE_ONES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (take1)
            begin
                v1_reg <= sample.valid;
            end
            if (take2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            flags1_reg <= flags_next;
        end
        if (ld.s2)
        begin
            flags2_reg <= flags1_reg;
        end
    end

    hfcc_lane #(
        .SPAN (hfcc_pkg::TEMP_SPAN)
    ) u_temp_lane (
        .clk        (clk),
        .ld         (ld),
        .word_high  (sample.temp_high),
        .word_low   (sample.temp_low),
        .word_check (sample.temp_check),
        .crc_ok     (temp_ok),
        .quot       (temp_quot)
    );

    hfcc_lane #(
        .SPAN (hfcc_pkg::HUM_SPAN)
    ) u_hum_lane (
        .clk        (clk),
        .ld         (ld),
        .word_high  (sample.hum_high),
        .word_low   (sample.hum_low),
        .word_check (sample.hum_check),
        .crc_ok     (hum_ok),
        .quot       (hum_quot)
    );

    hfcc_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (merge_ready),
        .flags     (flags2_reg),
        .temp_ok   (temp_ok),
        .temp_quot (temp_quot),
        .hum_ok    (hum_ok),
        .hum_quot  (hum_quot),
        .result    (result)
    );
endmodule
`default_nettype wire

// File: test/humidity_frame_check_convert_tb.sv
`timescale 1ns / 1ps

module humidity_frame_check_convert_tb;

    localparam int unsigned WORD_FULL    = 65535;
    localparam int          RANDOM_ITEMS = 450;
    localparam int          MAX_GAP      = 17;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          BURST_ITEMS  = 60;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct {
        logic       transfer_ok;
        logic [7:0] temp_high;
        logic [7:0] temp_low;
        logic [7:0] temp_check;
        logic [7:0] hum_high;
        logic [7:0] hum_low;
        logic [7:0] hum_check;
    } frame_t;

    typedef struct {
        hfcc_pkg::status_t  status;
        logic               temp_valid;
        logic signed [14:0] temperature_centi;
        logic               hum_valid;
        logic [13:0]        humidity_centi;
    } reading_t;

    class reading_scoreboard;
        reading_t pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // bitwise MSB-first CRC-8 over a 16-bit word
        static function logic [7:0] word_crc8(logic [15:0] w);
            logic [7:0] crc;
            logic       fb;
            crc = hfcc_pkg::CRC_INIT;
            for (int i = 15; i >= 0; i--)
            begin
                fb  = crc[7] ^ w[i];
                crc = {crc[6:0], 1'b0} ^ (fb ? hfcc_pkg::CRC_POLY : 8'h00);
            end
            return crc;
        endfunction

        static function reading_t convert_frame(frame_t f);
            reading_t    r;
            logic [15:0] tw;
            logic [15:0] hw;
            int unsigned scaled;
            tw                  = {f.temp_high, f.temp_low};
            hw                  = {f.hum_high, f.hum_low};
            r.status            = hfcc_pkg::ST_OK;
            r.temp_valid        = 1'b0;
            r.temperature_centi = '0;
            r.hum_valid         = 1'b0;
            r.humidity_centi    = '0;
            if (!f.transfer_ok)
                r.status = hfcc_pkg::ST_BUS;
            else if ({f.temp_high, f.temp_low, f.temp_check,
                      f.hum_high, f.hum_low, f.hum_check} == {6{hfcc_pkg::BYTE_ONES}})
                r.status = hfcc_pkg::ST_ALL_ONES;
            else if (word_crc8(tw) != f.temp_check)
                r.status = hfcc_pkg::ST_TEMP_CRC;
            else
            begin
                r.temp_valid        = 1'b1;
                scaled              = (hfcc_pkg::TEMP_SPAN * 32'(tw)) / WORD_FULL;
                r.temperature_centi = 15'(scaled - 32'(hfcc_pkg::TEMP_OFFSET));
                if (word_crc8(hw) != f.hum_check)
                    r.status = hfcc_pkg::ST_HUM_CRC;
                else
                begin
                    r.hum_valid      = 1'b1;
                    scaled           = (hfcc_pkg::HUM_SPAN * 32'(hw)) / WORD_FULL;
                    r.humidity_centi = 14'(scaled);
                end
            end
            return r;
        endfunction

        function void note_frame(frame_t f);
            pending.push_back(convert_frame(f));
        endfunction

        function void check_reading(reading_t got);
            reading_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result beat, status %0d", $realtime, got.status);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.temp_valid !== want.temp_valid ||
                got.temperature_centi !== want.temperature_centi ||
                got.hum_valid !== want.hum_valid ||
                got.humidity_centi !== want.humidity_centi)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: mismatch exp st=%0d tv=%0b t=%0d hv=%0b h=%0d",
                              " | got st=%0d tv=%0b t=%0d hv=%0b h=%0d"},
                             $realtime, want.status, want.temp_valid,
                             want.temperature_centi, want.hum_valid,
                             want.humidity_centi, got.status, got.temp_valid,
                             got.temperature_centi, got.hum_valid, got.humidity_centi);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    hfcc_in_if  sample_ch ();
    hfcc_out_if result_ch ();

    humidity_frame_check_convert dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    reading_scoreboard board = new();

    int cycles;
    bit send_quiet;
    bit hold_request;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL humidity_frame_check_convert");
            $finish;
        end
    end

    // note accepted frames before checking results so ordering holds at any latency
    always @(posedge clk)
    begin
        frame_t   f;
        reading_t r;
        if (rst_n && sample_ch.valid && sample_ch.ready)
        begin
            f.transfer_ok = sample_ch.transfer_ok;
            f.temp_high   = sample_ch.temp_high;
            f.temp_low    = sample_ch.temp_low;
            f.temp_check  = sample_ch.temp_check;
            f.hum_high    = sample_ch.hum_high;
            f.hum_low     = sample_ch.hum_low;
            f.hum_check   = sample_ch.hum_check;
            board.note_frame(f);
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            r.status            = hfcc_pkg::status_t'(result_ch.status);
            r.temp_valid        = result_ch.temp_valid;
            r.temperature_centi = result_ch.temperature_centi;
            r.hum_valid         = result_ch.hum_valid;
            r.humidity_centi    = result_ch.humidity_centi;
            board.check_reading(r);
        end
    end

    function automatic frame_t good_frame(logic [15:0] tw, logic [15:0] hw);
        frame_t f;
        f.transfer_ok = 1'b1;
        f.temp_high   = tw[15:8];
        f.temp_low    = tw[7:0];
        f.temp_check  = reading_scoreboard::word_crc8(tw);
        f.hum_high    = hw[15:8];
        f.hum_low     = hw[7:0];
        f.hum_check   = reading_scoreboard::word_crc8(hw);
        return f;
    endfunction

    function automatic frame_t all_ones_frame();
        frame_t f;
        f.transfer_ok = 1'b1;
        f.temp_high   = hfcc_pkg::BYTE_ONES;
        f.temp_low    = hfcc_pkg::BYTE_ONES;
        f.temp_check  = hfcc_pkg::BYTE_ONES;
        f.hum_high    = hfcc_pkg::BYTE_ONES;
        f.hum_low     = hfcc_pkg::BYTE_ONES;
        f.hum_check   = hfcc_pkg::BYTE_ONES;
        return f;
    endfunction

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly well-formed replies, the rest corrupted or plain noise
    function automatic frame_t random_frame();
        frame_t      f;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        f    = good_frame(random_word(), random_word());
        if (pick < 12)
            f.temp_check ^= 8'($urandom_range(1, 255));
        else if (pick < 24)
            f.hum_check ^= 8'($urandom_range(1, 255));
        else if (pick < 32)
            f.transfer_ok = 1'b0;
        else if (pick < 36)
            f = all_ones_frame();
        else if (pick < 44)
        begin
            f.transfer_ok = 1'($urandom);
            f.temp_high   = 8'($urandom);
            f.temp_low    = 8'($urandom);
            f.temp_check  = 8'($urandom);
            f.hum_high    = 8'($urandom);
            f.hum_low     = 8'($urandom);
            f.hum_check   = 8'($urandom);
        end
        return f;
    endfunction

    task automatic send_frame(frame_t f);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.transfer_ok <= f.transfer_ok;
        sample_ch.temp_high   <= f.temp_high;
        sample_ch.temp_low    <= f.temp_low;
        sample_ch.temp_check  <= f.temp_check;
        sample_ch.hum_high    <= f.hum_high;
        sample_ch.hum_low     <= f.hum_low;
        sample_ch.hum_check   <= f.hum_check;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // result side: random stalls, quiet stretches, one long hold-off on request
    initial
    begin
        int stall;
        int beats;
        bit quiet;
        beats = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            beats++;
            if (beats % 50 == 0)
                quiet = ($urandom_range(0, 2) == 0);
        end
    end

    initial
    begin
        frame_t f;
        cycles                = 0;
        send_quiet            = 1'b0;
        hold_request          = 1'b0;
        rst_n                 = 1'b0;
        sample_ch.valid       <= 1'b0;
        sample_ch.transfer_ok <= 1'b0;
        sample_ch.temp_high   <= '0;
        sample_ch.temp_low    <= '0;
        sample_ch.temp_check  <= '0;
        sample_ch.hum_high    <= '0;
        sample_ch.hum_low     <= '0;
        sample_ch.hum_check   <= '0;
        result_ch.ready       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: scale extremes, each status, near misses of the all-ones reply
        send_frame(good_frame(16'h0000, 16'h0000));
        send_frame(good_frame(16'hFFFF, 16'hFFFF));
        send_frame(good_frame(16'h8000, 16'h7FFF));
        send_frame(good_frame(16'hFFFE, 16'h0001));
        send_frame(good_frame(16'hBEEF, 16'hBEEF));
        f = all_ones_frame();
        f.transfer_ok = 1'b0;
        send_frame(f);
        f = good_frame(16'h1234, 16'h5678);
        f.transfer_ok = 1'b0;
        send_frame(f);
        send_frame(all_ones_frame());
        f = all_ones_frame();
        f.hum_check = 8'hFE;
        send_frame(f);
        f = all_ones_frame();
        f.temp_high = 8'hFE;
        send_frame(f);
        f = good_frame(16'hFFFF, 16'hFFFF);
        f.hum_check = hfcc_pkg::BYTE_ONES;
        send_frame(f);
        f = good_frame(16'h6666, 16'h9999);
        f.temp_check ^= 8'h01;
        send_frame(f);
        f = good_frame(16'h6666, 16'h9999);
        f.temp_check ^= 8'h80;
        f.hum_check  ^= 8'h80;
        send_frame(f);
        f = good_frame(16'h0000, 16'hABCD);
        f.hum_check ^= 8'h01;
        send_frame(f);
        f = good_frame(16'hFFFF, 16'hFFFF);
        f.hum_check ^= 8'h40;
        send_frame(f);
        f = good_frame(16'h0000, 16'h0000);
        f.temp_check = 8'h00;
        f.hum_check  = 8'h00;
        send_frame(f);
        send_quiet = 1'b1;
        send_frame(good_frame(16'h0001, 16'hFFFE));
        send_frame(good_frame(16'h7FFF, 16'h8000));
        send_frame(all_ones_frame());
        send_quiet = 1'b0;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200)
                hold_request = 1'b1;
            if (i >= 200 && i < 200 + BURST_ITEMS)
                send_quiet = 1'b1;
            else if (i % 40 == 0)
                send_quiet = ($urandom_range(0, 2) == 0);
            send_frame(random_frame());
        end
        sample_ch.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("PASS humidity_frame_check_convert");
        else
            $display("FAIL humidity_frame_check_convert");
        $finish;
    end

endmodule
